// File: hw/rtl/mt19937_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 package
// Types, constants and word functions shared by the MT19937 generator.
// ----------------------------------------------------------------------------
package mt19937_pkg;

	localparam int unsigned TWIST_OFFSET = 397;

	localparam logic [31:0] DEFAULT_SEED  = 32'd5489;
	localparam logic [31:0] SEED_MULT     = 32'h6c078965;
	localparam logic [31:0] TWIST_MATRIX  = 32'h9908b0df;
	localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_MASK_C = 32'hefc60000;
	localparam logic [31:0] UPPER_BIT     = 32'h80000000;
	localparam logic [31:0] LOWER_BITS    = 32'h7fffffff;

	localparam logic KIND_SEED = 1'b0;
	localparam logic KIND_NEXT = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ_FAR,
		ST_TWIST,
		ST_SEED_MUL,
		ST_SEED_ADD
	} mt_state_t;

	function automatic logic [31:0] seed_mix(input logic [31:0] p);
		logic [31:0] mixed;
		mixed = p ^ (p >> 30);
		return SEED_MULT * mixed;
	endfunction

	function automatic logic [31:0] twist_word(input logic [31:0] y, input logic [31:0] far);
		logic [31:0] v;
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_MATRIX;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_MASK_B);
		y = y ^ ((y << 15) & TEMPER_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: hw/rtl/mt19937_ram.sv
// ----------------------------------------------------------------------------
// MT19937 state RAM
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mt19937_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hw/rtl/mt19937_generator.sv
// ----------------------------------------------------------------------------
// MT19937 generator
// 32-bit Mersenne Twister; the state words are twisted one at a time as
// they are consumed.
// ----------------------------------------------------------------------------
// A next beat (kind 1) is accepted when start is high and busy is low; its
// tempered word appears on random_word with strobe high for one cycle, after
// the two reads of the state RAM and its write-back, and a new beat may be
// started as soon as busy drops, which is in that same cycle; no beat is
// taken while one is in flight. A seed beat (kind 0) gives no result and keeps
// busy high while the seed recurrence, one multiply and one add per word,
// refills the RAM. After reset the block runs the same fill with seed 5489,
// busy for the whole fill. The receiver cannot stall: every strobe is a
// delivered word.
// ----------------------------------------------------------------------------
module mt19937_generator #(
	parameter int STATE_WORDS = 624
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] seed_value,
	output logic        strobe,
	output logic [31:0] random_word
);

	import mt19937_pkg::*;

	localparam int AW = $clog2(STATE_WORDS);
	localparam int LOW_SPAN = STATE_WORDS - TWIST_OFFSET;

	mt_state_t state_q, state_d;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] idx_q;
	logic          strobe_q;
	logic [31:0]   prev_q;
	logic [31:0]   prod_q;
	logic [31:0]   y_q;
	logic [31:0]   random_word_q;

	logic          accept;
	logic [AW-1:0] far_addr;
	logic [AW-1:0] next_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr_a;
	logic [31:0]   rdata_a;
	logic [31:0]   rdata_b;
	logic [31:0]   twist_v;
	logic [31:0]   seed_sum;
	logic          seed_last;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign strobe      = strobe_q;
	assign random_word = random_word_q;

	assign far_addr  = (ptr_q < AW'(LOW_SPAN)) ? ptr_q + AW'(TWIST_OFFSET)
		: ptr_q - AW'(LOW_SPAN);
	assign next_addr = (ptr_q == AW'(STATE_WORDS - 1)) ? '0 : ptr_q + AW'(1);
	assign raddr_a   = (state_q == ST_READ_FAR) ? far_addr : ptr_q;
	assign twist_v   = twist_word(y_q, rdata_a);
	assign seed_sum  = prod_q + 32'(idx_q);
	assign seed_last = (idx_q == AW'(STATE_WORDS - 1));

	mt19937_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(next_addr),
		.rdata_b(rdata_b)
	);

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = ptr_q;
		wdata   = twist_v;
		case (state_q)
			ST_INIT: begin
				we      = 1'b1;
				waddr   = '0;
				wdata   = DEFAULT_SEED;
				state_d = ST_SEED_MUL;
			end
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_NEXT) begin
						state_d = ST_READ_FAR;
					end else begin
						we      = 1'b1;
						waddr   = '0;
						wdata   = seed_value;
						state_d = ST_SEED_MUL;
					end
				end
			end
			ST_READ_FAR: begin
				state_d = ST_TWIST;
			end
			ST_TWIST: begin
				we      = 1'b1;
				waddr   = ptr_q;
				wdata   = twist_v;
				state_d = ST_IDLE;
			end
			ST_SEED_MUL: begin
				state_d = ST_SEED_ADD;
			end
			ST_SEED_ADD: begin
				we      = 1'b1;
				waddr   = idx_q;
				wdata   = seed_sum;
				state_d = seed_last ? ST_IDLE : ST_SEED_MUL;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			ptr_q    <= '0;
			idx_q    <= AW'(1);
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_TWIST);
			if (state_q == ST_TWIST) begin
				ptr_q <= next_addr;
			end else if (accept && kind == KIND_SEED) begin
				ptr_q <= '0;
			end
			if (state_q == ST_INIT || (accept && kind == KIND_SEED)) begin
				idx_q <= AW'(1);
			end else if (state_q == ST_SEED_ADD) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			prev_q <= DEFAULT_SEED;
		end else if (accept && kind == KIND_SEED) begin
			prev_q <= seed_value;
		end else if (state_q == ST_SEED_ADD) begin
			prev_q <= seed_sum;
		end
		if (state_q == ST_SEED_MUL) begin
			prod_q <= seed_mix(prev_q);
		end
		if (state_q == ST_READ_FAR) begin
			y_q <= (rdata_a & UPPER_BIT) | (rdata_b & LOWER_BITS);
		end
		if (state_q == ST_TWIST) begin
			random_word_q <= temper(twist_v);
		end
	end

	a_strobe_after_twist: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_TWIST))
		else $error("strobe without a twist write-back");

	a_next_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_NEXT) |=> ##2 strobe)
		else $error("next beat did not produce a word");

	a_seed_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_SEED) |=> !strobe ##1 !strobe)
		else $error("seed beat produced a word");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= AW'(STATE_WORDS - 1))
		else $error("word pointer out of range");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (waddr <= AW'(STATE_WORDS - 1)))
		else $error("state write address out of range");

endmodule
